>>> design/lus_pkg.sv
// ----------------------------------------------------------------------------
// lus_pkg
// Shared widths, limits and types for the longest repeat-free substring block.
// ----------------------------------------------------------------------------
package lus_pkg;

  // Symbol and position ranges
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned SYM_COUNT = 1 << SYM_W;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned LEN_W     = POS_W + 1;
  localparam int unsigned OUT_W     = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [LEN_W-1:0] OUT_MAX = LEN_W'({OUT_W{1'b1}});

  // Result buffer
  localparam int unsigned RES_DEPTH = 3;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  // One result word as held in the output buffer
  typedef struct packed {
    logic             overflow;
    logic             final_res;
    logic [OUT_W-1:0] max_len;
    logic [OUT_W-1:0] window_len;
  } res_t;

endpackage

>>> design/lus_ram.sv
// ----------------------------------------------------------------------------
// lus_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lus_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/longest_unique_substring_len.sv
// An accepted word passes the stage register, then the result buffer, to the output.
// One word per cycle while tready is high; the last-seen table read at accept, with the
//   next-cycle write forwarded to a back-to-back same-symbol reader, sets this rate.
// A three-entry result buffer lets input flow while the output side stalls.
// Reset (rst_ni low, asynchronous) clears valid marks, window, position, best length,
//   overflow and the buffer; the position table itself is never cleared.
// ----------------------------------------------------------------------------
// longest_unique_substring_len
// Streams a string one symbol per word and reports, for each symbol, the
// repeat-free window length ending there and the running maximum.
// ----------------------------------------------------------------------------
module longest_unique_substring_len (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] symbol
  input  logic        s_axis_tlast_i,   // last
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [15:0] window_len, [31:16] max_len
  output logic        m_axis_tlast_o,   // final_res
  output logic        m_axis_tuser_o    // [0] overflow
);

  localparam int unsigned SW = lus_pkg::SYM_W;
  localparam int unsigned PW = lus_pkg::POS_W;
  localparam int unsigned LW = lus_pkg::LEN_W;
  localparam int unsigned OW = lus_pkg::OUT_W;

  logic          in_acc;
  logic [SW-1:0] in_sym;
  logic          out_acc;

  // compute stage
  logic          s1_valid_q;
  logic [SW-1:0] s1_sym_q;
  logic          s1_last_q;

  // forwarding of the write that overlapped this word's read
  logic          fwd_hit_q;
  logic [PW-1:0] fwd_pos_q;

  // per-string state
  logic [lus_pkg::SYM_COUNT-1:0] valid_q, valid_d;
  logic [PW-1:0] wstart_q, wstart_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [LW-1:0] best_q, best_d;
  logic          ovf_q, ovf_d;

  logic [PW-1:0] ram_rdata;
  logic [PW-1:0] seen_pos;
  logic          seen_valid;
  logic          hit;
  logic [LW-1:0] next_start;
  logic [LW-1:0] len;
  logic          ovf_now;

  // result buffer
  lus_pkg::res_t                   res_q [lus_pkg::RES_DEPTH];
  lus_pkg::res_t                   res_new;
  logic [lus_pkg::RES_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lus_pkg::RES_CNT_W-1:0]   cnt_q, cnt_d;

  assign in_sym  = s_axis_tdata_i[SW-1:0];
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // room for every word in flight
  assign s_axis_tready_o =
      (cnt_q + lus_pkg::RES_CNT_W'(s1_valid_q)) < lus_pkg::RES_CNT_W'(lus_pkg::RES_DEPTH);

  // last-seen position table
  lus_ram #(
    .WIDTH (PW),
    .DEPTH (lus_pkg::SYM_COUNT)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_sym_q),
    .wdata_i (pos_q),
    .re_i    (in_acc),
    .raddr_i (in_sym),
    .rdata_o (ram_rdata)
  );

  // stage register and forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        fwd_hit_q <= s1_valid_q && !s1_last_q && (in_sym == s1_sym_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sym_q  <= in_sym;
      s1_last_q <= s_axis_tlast_i;
      fwd_pos_q <= pos_q;
    end
  end

  // window update
  always_comb begin
    seen_pos   = fwd_hit_q ? fwd_pos_q : ram_rdata;
    seen_valid = valid_q[s1_sym_q];
    ovf_now    = ovf_q || (pos_q == lus_pkg::POS_MAX);
    hit        = seen_valid && (seen_pos >= wstart_q);
    next_start = {1'b0, seen_pos} + LW'(1);
    wstart_d   = wstart_q;
    if (hit) begin
      wstart_d = (next_start > {1'b0, pos_q}) ? pos_q : next_start[PW-1:0];
    end
    len    = {1'b0, pos_q} - {1'b0, wstart_d} + LW'(1);
    best_d = (len > best_q) ? len : best_q;
    ovf_d  = ovf_now;
    pos_d  = (pos_q == lus_pkg::POS_MAX) ? pos_q : pos_q + PW'(1);
    valid_d = valid_q;
    valid_d[s1_sym_q] = 1'b1;
    if (s1_last_q) begin
      valid_d  = '0;
      wstart_d = '0;
      pos_d    = '0;
      best_d   = '0;
      ovf_d    = 1'b0;
    end

    res_new.window_len = (len > lus_pkg::OUT_MAX) ? OW'(lus_pkg::OUT_MAX) : len[OW-1:0];
    res_new.max_len    = ((len > best_q ? len : best_q) > lus_pkg::OUT_MAX) ?
                         OW'(lus_pkg::OUT_MAX) : (len > best_q ? len[OW-1:0] : best_q[OW-1:0]);
    res_new.final_res  = s1_last_q;
    res_new.overflow   = ovf_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      wstart_q <= '0;
      pos_q    <= '0;
      best_q   <= '0;
      ovf_q    <= 1'b0;
    end else if (s1_valid_q) begin
      valid_q  <= valid_d;
      wstart_q <= wstart_d;
      pos_q    <= pos_d;
      best_q   <= best_d;
      ovf_q    <= ovf_d;
    end
  end

  // result buffer
  always_comb begin
    cnt_d = cnt_q;
    if (s1_valid_q && !out_acc) begin
      cnt_d = cnt_q + lus_pkg::RES_CNT_W'(1);
    end else if (!s1_valid_q && out_acc) begin
      cnt_d = cnt_q - lus_pkg::RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (s1_valid_q) begin
        wr_ptr_q <= (wr_ptr_q == lus_pkg::RES_PTR_W'(lus_pkg::RES_DEPTH - 1)) ?
                    '0 : wr_ptr_q + lus_pkg::RES_PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= (rd_ptr_q == lus_pkg::RES_PTR_W'(lus_pkg::RES_DEPTH - 1)) ?
                    '0 : rd_ptr_q + lus_pkg::RES_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {res_q[rd_ptr_q].max_len, res_q[rd_ptr_q].window_len};
  assign m_axis_tlast_o  = res_q[rd_ptr_q].final_res;
  assign m_axis_tuser_o  = res_q[rd_ptr_q].overflow;

endmodule

>>> design/lus_checker.sv
// ----------------------------------------------------------------------------
// lus_checker
// Port-level checks for the longest repeat-free substring block.
// ----------------------------------------------------------------------------
module lus_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pend_q;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // words accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  // no result without a word behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pend_q != 3'd0))
    else $error("result shown with no word pending");

  // at most the stage and the buffer in flight
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4)
    else $error("too many words in flight");

  // window is never empty and never longer than the maximum
  a_len_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:0] != 16'd0) &&
                        (m_axis_tdata_o[31:16] >= m_axis_tdata_o[15:0]))
    else $error("window length out of order with maximum");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind longest_unique_substring_len lus_checker u_lus_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
